// ===== rtl/core/adagrad_dense_update_defines.svh =====
// Assertion helpers shared by the RTL.
`ifndef ADAGRAD_DENSE_UPDATE_DEFINES_SVH
`define ADAGRAD_DENSE_UPDATE_DEFINES_SVH

// Check a condition at every clock edge out of reset.
`define ADA_ASSERT_ALWAYS(lbl, cond) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error("assertion failed");

// Check that an antecedent implies a consequent in the same cycle.
`define ADA_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

`endif

// ===== rtl/core/ada_pkg.sv =====
package ada_pkg;

    // Configuration register indexes
    localparam logic [1:0] CFG_LR  = 2'd0;
    localparam logic [1:0] CFG_EPS = 2'd1;

    localparam int unsigned SQ_STAGES  = 24;
    localparam int unsigned DIV_STAGES = 56;

    // Data carried alongside the root pipeline
    typedef struct packed {
        logic [31:0] p;
        logic        neg;
        logic [31:0] nm;
        logic [55:0] num;
    } t_sq_side;

    // Data carried alongside the divider pipeline
    typedef struct packed {
        logic [31:0] p;
        logic        neg;
        logic [31:0] nm;
    } t_dv_side;

endpackage

// ===== rtl/core/adagrad_dense_update.sv =====
// Adagrad element update, fully pipelined.
// Throughput: one request per cycle; busy stays low, the pipeline never stalls.
// Depth is set by the 24-stage square root and the 56-stage divider.
// Reset (synchronous, active low) clears all valid bits and loads
// the step size to 655 and epsilon to 1; the receiver cannot stall.
`include "adagrad_dense_update_defines.svh"

module adagrad_dense_update (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_idx,
    input  logic [23:0]        i_cfg_data,
    input  logic signed [31:0] i_param_value,
    input  logic signed [31:0] i_grad_value,
    input  logic [31:0]        i_moment_value,
    output logic               o_result_valid,
    output logic signed [31:0] o_new_param,
    output logic [31:0]        o_new_moment
);
    import ada_pkg::*;

    // Configuration registers
    logic [23:0] r_lr;
    logic [15:0] r_eps;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lr  <= 24'd655;
            r_eps <= 16'd1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_LR:  r_lr  <= i_cfg_data;
                CFG_EPS: r_eps <= i_cfg_data[15:0];
                default: ; // drop writes to unknown indexes
            endcase
        end
    end

    // The pipeline always advances, so a request is never held off
    assign busy = 1'b0;

    // Stage 0: capture the request and take the gradient magnitude
    logic        w_accept;
    logic        w_neg;
    logic [31:0] w_gmag;
    logic        r0_v;
    logic [31:0] r0_p;
    logic        r0_neg;
    logic [31:0] r0_gmag;
    logic [31:0] r0_m;

    assign w_accept = start && !busy;
    assign w_neg    = i_grad_value[31];
    assign w_gmag   = w_neg ? (~i_grad_value + 32'd1) : i_grad_value;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_v <= 1'b0;
        end else begin
            r0_v <= w_accept;
        end
        r0_p    <= i_param_value;
        r0_neg  <= w_neg;
        r0_gmag <= w_gmag;
        r0_m    <= i_moment_value;
    end

    // Stage 1: square the gradient and form the step numerator in parallel
    logic        r1_v;
    logic [31:0] r1_p;
    logic        r1_neg;
    logic [31:0] r1_m;
    logic [63:0] r1_sq;
    logic [55:0] r1_num;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else begin
            r1_v <= r0_v;
        end
        r1_p   <= r0_p;
        r1_neg <= r0_neg;
        r1_m   <= r0_m;
        r1_sq  <= 64'(r0_gmag) * 64'(r0_gmag);
        r1_num <= 56'(r_lr) * 56'(r0_gmag);
    end

    // Stage 2: accumulate the moment, saturating at all ones
    logic [48:0] w_msum;
    logic [31:0] w_nm;
    logic        r2_v;
    logic [31:0] r2_nm;
    t_sq_side    r2_side;

    assign w_msum = 49'(r1_m) + 49'(r1_sq[63:16]);
    assign w_nm   = (w_msum[48:32] != '0) ? '1 : w_msum[31:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_v <= 1'b0;
        end else begin
            r2_v <= r1_v;
        end
        r2_nm        <= w_nm;
        r2_side.p    <= r1_p;
        r2_side.neg  <= r1_neg;
        r2_side.nm   <= w_nm;
        r2_side.num  <= r1_num;
    end

    // Square root of the moment in Q16.16
    logic        w_sq_v;
    logic [23:0] w_root;
    t_sq_side    w_sq_side;

    ada_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r2_v),
        .i_x     ({r2_nm, 16'h0000}),
        .i_side  (r2_side),
        .o_valid (w_sq_v),
        .o_root  (w_root),
        .o_side  (w_sq_side)
    );

    // Divisor stage: add epsilon, a zero epsilon acting as one LSB
    logic [15:0] w_eps;
    logic        r_d_v;
    logic [24:0] r_d;
    logic [55:0] r_d_num;
    t_dv_side    r_d_side;

    assign w_eps = (r_eps == '0) ? 16'd1 : r_eps;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_v <= 1'b0;
        end else begin
            r_d_v <= w_sq_v;
        end
        r_d          <= 25'(w_root) + 25'(w_eps);
        r_d_num      <= w_sq_side.num;
        r_d_side.p   <= w_sq_side.p;
        r_d_side.neg <= w_sq_side.neg;
        r_d_side.nm  <= w_sq_side.nm;
    end

    // Step magnitude = numerator / divisor, truncated
    logic        w_dv_v;
    logic [55:0] w_quot;
    t_dv_side    w_dv_side;

    ada_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_d_v),
        .i_num   (r_d_num),
        .i_den   (r_d),
        .i_side  (r_d_side),
        .o_valid (w_dv_v),
        .o_quot  (w_quot),
        .o_side  (w_dv_side)
    );

    // Output stage: apply the signed step and clamp to 32 bits
    localparam logic signed [57:0] PMAX = 58'sd2147483647;
    localparam logic signed [57:0] PMIN = -58'sd2147483648;

    logic signed [57:0] w_pext;
    logic signed [57:0] w_step;
    logic signed [57:0] w_np;
    logic signed [31:0] w_np_sat;

    assign w_pext = 58'(signed'(w_dv_side.p));
    assign w_step = signed'({2'b00, w_quot});
    assign w_np   = w_dv_side.neg ? (w_pext + w_step) : (w_pext - w_step);

    always_comb begin
        if (w_np > PMAX) begin
            w_np_sat = 32'h7FFF_FFFF;
        end else if (w_np < PMIN) begin
            w_np_sat = 32'h8000_0000;
        end else begin
            w_np_sat = w_np[31:0];
        end
    end

    logic               r_out_v;
    logic signed [31:0] r_out_p;
    logic [31:0]        r_out_m;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else begin
            r_out_v <= w_dv_v;
        end
        r_out_p <= w_np_sat;
        r_out_m <= w_dv_side.nm;
    end

    assign o_result_valid = r_out_v;
    assign o_new_param    = r_out_p;
    assign o_new_moment   = r_out_m;

    // Checks
    `ADA_ASSERT_IMPL(a_div_nonzero, r_d_v, r_d != '0)
    `ADA_ASSERT_IMPL(a_moment_grows, r2_v, r2_nm >= $past(r1_m))
    `ADA_ASSERT_IMPL(a_step_dir, w_dv_v && !w_dv_side.neg, w_np_sat <= signed'(w_dv_side.p))

endmodule

// ===== rtl/core/ada_sqrt.sv =====
module ada_sqrt (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic [47:0]       i_x,
    input  ada_pkg::t_sq_side i_side,
    output logic              o_valid,
    output logic [23:0]       o_root,
    output ada_pkg::t_sq_side o_side
);
    import ada_pkg::*;

    logic [47:0] r_x    [SQ_STAGES];
    logic [47:0] r_r    [SQ_STAGES];
    logic        r_v    [SQ_STAGES];
    t_sq_side    r_side [SQ_STAGES];

    // One result bit per stage
    for (genvar k = 0; k < SQ_STAGES; k++) begin : g_stage
        localparam logic [47:0] BIT = 48'(1) << (46 - 2 * k);
        logic [47:0] w_x;
        logic [47:0] w_r;
        logic        w_v;
        t_sq_side    w_side;
        logic [48:0] w_trial;
        logic [47:0] n_x;
        logic [47:0] n_r;

        if (k == 0) begin : g_first
            assign w_x    = i_x;
            assign w_r    = '0;
            assign w_v    = i_valid;
            assign w_side = i_side;
        end else begin : g_next
            assign w_x    = r_x[k-1];
            assign w_r    = r_r[k-1];
            assign w_v    = r_v[k-1];
            assign w_side = r_side[k-1];
        end

        always_comb begin
            w_trial = {1'b0, w_r} + {1'b0, BIT};
            if ({1'b0, w_x} >= w_trial) begin
                n_x = 48'({1'b0, w_x} - w_trial);
                n_r = (w_r >> 1) + BIT;
            end else begin
                n_x = w_x;
                n_r = w_r >> 1;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else begin
                r_v[k] <= w_v;
            end
            r_x[k]    <= n_x;
            r_r[k]    <= n_r;
            r_side[k] <= w_side;
        end
    end

    assign o_valid = r_v[SQ_STAGES-1];
    assign o_root  = r_r[SQ_STAGES-1][23:0];
    assign o_side  = r_side[SQ_STAGES-1];

endmodule

// ===== rtl/core/ada_div.sv =====
module ada_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic [55:0]       i_num,
    input  logic [24:0]       i_den,
    input  ada_pkg::t_dv_side i_side,
    output logic              o_valid,
    output logic [55:0]       o_quot,
    output ada_pkg::t_dv_side o_side
);
    import ada_pkg::*;

    logic [24:0] r_rem  [DIV_STAGES];
    logic [55:0] r_num  [DIV_STAGES];
    logic [55:0] r_q    [DIV_STAGES];
    logic [24:0] r_den  [DIV_STAGES];
    logic        r_v    [DIV_STAGES];
    t_dv_side    r_side [DIV_STAGES];

    // Restoring division, one quotient bit per stage, MSB first
    for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
        logic [24:0] w_rem;
        logic [55:0] w_num;
        logic [55:0] w_q;
        logic [24:0] w_den;
        logic        w_v;
        t_dv_side    w_side;
        logic [25:0] w_shift;
        logic        w_ge;

        if (k == 0) begin : g_first
            assign w_rem  = '0;
            assign w_num  = i_num;
            assign w_q    = '0;
            assign w_den  = i_den;
            assign w_v    = i_valid;
            assign w_side = i_side;
        end else begin : g_next
            assign w_rem  = r_rem[k-1];
            assign w_num  = r_num[k-1];
            assign w_q    = r_q[k-1];
            assign w_den  = r_den[k-1];
            assign w_v    = r_v[k-1];
            assign w_side = r_side[k-1];
        end

        assign w_shift = {w_rem, w_num[55]};
        assign w_ge    = w_shift >= {1'b0, w_den};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else begin
                r_v[k] <= w_v;
            end
            r_rem[k]  <= w_ge ? 25'(w_shift - {1'b0, w_den}) : w_shift[24:0];
            r_num[k]  <= w_num << 1;
            r_q[k]    <= {w_q[54:0], w_ge};
            r_den[k]  <= w_den;
            r_side[k] <= w_side;
        end
    end

    assign o_valid = r_v[DIV_STAGES-1];
    assign o_quot  = r_q[DIV_STAGES-1];
    assign o_side  = r_side[DIV_STAGES-1];

endmodule
